// File: sv/ubx_pkg.sv
// ubx_pkg: shared types and constants of the binary frame parser
// parse phase codes, event codes, sync bytes and register map
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package ubx_pkg;

	localparam logic [7:0] SYNC_FIRST = 8'hB5;
	localparam logic [7:0] SYNC_SECOND = 8'h62;
	localparam logic [15:0] LIMIT_RESET = 16'd872;

	localparam int EV_W = 3;
	localparam logic [EV_W-1:0] EV_NONE = 3'd0;
	localparam logic [EV_W-1:0] EV_DATA = 3'd1;
	localparam logic [EV_W-1:0] EV_GOOD = 3'd2;
	localparam logic [EV_W-1:0] EV_BADSUM = 3'd3;
	localparam logic [EV_W-1:0] EV_TOOLONG = 3'd4;

	localparam logic REG_MAX_LEN = 1'b0;

	typedef enum logic [8:0] {
		PH_SYNC1 = 9'b000000001,
		PH_SYNC2 = 9'b000000010,
		PH_CLASS = 9'b000000100,
		PH_IDENT = 9'b000001000,
		PH_LEN_LO = 9'b000010000,
		PH_LEN_HI = 9'b000100000,
		PH_PAYLOAD = 9'b001000000,
		PH_CK_A = 9'b010000000,
		PH_CK_B = 9'b100000000
	} phase_t;

	typedef struct packed {
		logic [15:0] payload_len;
		logic [7:0] msg_id;
		logic [7:0] class_byte;
		logic [15:0] byte_index;
		logic [7:0] data_byte;
	} result_t;

endpackage

`default_nettype wire

// File: sv/ubx_frame_parser_top.sv
// ubx_frame_parser_top: binary frame parser with fletcher-8 checksum check
// stream in, stream out, apb register for the payload length limit; uses ubx_pkg
`timescale 1ns / 1ps
`default_nettype none

// Returns exactly one result word per received byte, registered in the cycle
// after the byte is accepted. The parser state (phase, the two fletcher sums,
// header fields and payload count) is updated once per accepted byte, so
// sustained rate is one byte per cycle unless stalled. One output register
// holds the result; a new byte is taken whenever that register is empty or is
// being drained in the same cycle. The result kind travels in tuser; the
// consumer must drop streamed payload bytes unless the frame ends with a good
// event. The length limit register sits at byte address 0 and resets to 872.
module ubx_frame_parser_top (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_axis_tvalid,
	output logic        s_axis_tready,
	input  wire  [7:0]  s_axis_tdata,   // rx_byte
	output logic        m_axis_tvalid,
	input  wire         m_axis_tready,
	output logic [55:0] m_axis_tdata,   // data_byte, byte_index, class_byte, msg_id, payload_len
	output logic [2:0]  m_axis_tuser,   // event_res
	input  wire         psel,
	input  wire         penable,
	input  wire         pwrite,
	input  wire  [2:0]  paddr,
	input  wire  [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ubx_pkg::*;

	phase_t phase_q, phase_d;
	logic [7:0] sum_a_q, sum_a_d, sum_b_q, sum_b_d;
	logic [7:0] class_q, class_d, ident_q, ident_d;
	logic [15:0] len_q, len_d, count_q, count_d;
	logic [15:0] max_len_q;
	logic [EV_W-1:0] ev;
	logic [7:0] data_out;
	logic [15:0] idx_out;
	logic [7:0] b;
	logic [7:0] acc_a;
	logic [15:0] count_inc;
	logic [15:0] len_full;
	logic in_acc;
	logic out_acc;
	logic cfg_wr;
	result_t res_d;

	assign b = s_axis_tdata;
	assign acc_a = sum_a_q + b;
	assign count_inc = count_q + 16'd1;
	assign len_full = {b, len_q[7:0]};
	assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign out_acc = m_axis_tvalid && m_axis_tready;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_MAX_LEN) ? {16'd0, max_len_q} : 32'd0;

	always_comb begin
		phase_d = phase_q;
		sum_a_d = sum_a_q;
		sum_b_d = sum_b_q;
		class_d = class_q;
		ident_d = ident_q;
		len_d = len_q;
		count_d = count_q;
		ev = EV_NONE;
		data_out = 8'd0;
		idx_out = 16'd0;
		unique case (phase_q)
			PH_SYNC2: begin
				phase_d = (b == SYNC_SECOND) ? PH_CLASS : PH_SYNC1;
			end
			PH_CLASS: begin
				class_d = b;
				sum_a_d = b;
				sum_b_d = b;
				phase_d = PH_IDENT;
			end
			PH_IDENT: begin
				ident_d = b;
				sum_a_d = acc_a;
				sum_b_d = sum_b_q + acc_a;
				phase_d = PH_LEN_LO;
			end
			PH_LEN_LO: begin
				len_d = {8'd0, b};
				sum_a_d = acc_a;
				sum_b_d = sum_b_q + acc_a;
				phase_d = PH_LEN_HI;
			end
			PH_LEN_HI: begin
				len_d = len_full;
				sum_a_d = acc_a;
				sum_b_d = sum_b_q + acc_a;
				priority if (len_full == 16'd0) begin
					phase_d = PH_CK_A;
				end else if (len_full <= max_len_q) begin
					count_d = 16'd0;
					phase_d = PH_PAYLOAD;
				end else begin
					ev = EV_TOOLONG;
					phase_d = PH_SYNC1;
				end
			end
			PH_PAYLOAD: begin
				ev = EV_DATA;
				data_out = b;
				idx_out = count_q;
				sum_a_d = acc_a;
				sum_b_d = sum_b_q + acc_a;
				count_d = count_inc;
				if (count_inc == len_q) begin
					phase_d = PH_CK_A;
				end
			end
			PH_CK_A: begin
				if (b == sum_a_q) begin
					phase_d = PH_CK_B;
				end else begin
					ev = EV_BADSUM;
					phase_d = PH_SYNC1;
				end
			end
			PH_CK_B: begin
				ev = (b == sum_b_q) ? EV_GOOD : EV_BADSUM;
				phase_d = PH_SYNC1;
			end
			default: begin
				phase_d = (b == SYNC_FIRST) ? PH_SYNC2 : PH_SYNC1;
			end
		endcase

		res_d.data_byte = data_out;
		res_d.byte_index = idx_out;
		if (ev == EV_NONE) begin
			res_d.class_byte = 8'd0;
			res_d.msg_id = 8'd0;
			res_d.payload_len = 16'd0;
		end else begin
			res_d.class_byte = class_d;
			res_d.msg_id = ident_d;
			res_d.payload_len = len_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SYNC1;
			sum_a_q <= 8'd0;
			sum_b_q <= 8'd0;
			class_q <= 8'd0;
			ident_q <= 8'd0;
			len_q <= 16'd0;
			count_q <= 16'd0;
		end else if (in_acc) begin
			phase_q <= phase_d;
			sum_a_q <= sum_a_d;
			sum_b_q <= sum_b_d;
			class_q <= class_d;
			ident_q <= ident_d;
			len_q <= len_d;
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= LIMIT_RESET;
		end else if (cfg_wr && paddr[2] == REG_MAX_LEN) begin
			max_len_q <= pwdata[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (in_acc) begin
			m_axis_tvalid <= 1'b1;
		end else if (out_acc) begin
			m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			m_axis_tdata <= res_d;
			m_axis_tuser <= ev;
		end
	end

	// payload count never reaches the declared length while in payload
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_PAYLOAD |-> count_q < len_q)
		else $error("payload count ran past frame length");

	// a streamed payload byte carries an index inside the declared length
	a_index_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == EV_DATA |->
			m_axis_tdata[23:8] < m_axis_tdata[55:40])
		else $error("payload index outside frame length");

	// an empty event carries an all-zero word
	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser == EV_NONE |-> m_axis_tdata == 56'd0)
		else $error("empty event with nonzero word");

	// every accepted byte leaves a result waiting in the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> m_axis_tvalid)
		else $error("accepted byte produced no result");

	// fletcher sums are loaded from the class byte
	a_class_load: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && phase_q == PH_CLASS |=>
			sum_a_q == sum_b_q && sum_a_q == class_q)
		else $error("checksum not seeded from class byte");

endmodule

`default_nettype wire
